// ===== rtl/crle_pkg.sv =====
package crle_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned AddrW     = 2 * IdxW;
  localparam int unsigned DistW     = 24;
  localparam int unsigned LenW      = 32;
  localparam int unsigned CountW    = 7;
  // facility number plus node count, wide enough for the largest pair
  localparam int unsigned RowW      = CountW + 1;

  localparam logic OpWrite = 1'b0;
  localparam logic OpRoute = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [IdxW-1:0]  row_index;
    logic [IdxW-1:0]  col_index;
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  facility_index;
    logic [IdxW-1:0]  node_index;
    logic             first_of_route;
    logic             last_of_route;
  } in_item_t;

  typedef struct packed {
    logic [LenW-1:0] route_length;
    logic            saturated;
    logic            index_error;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic add;
  } accum_ctrl_t;

endpackage

// ===== rtl/crle_table.sv =====
module crle_table (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [crle_pkg::AddrW-1:0] waddr_i,
  input  logic [crle_pkg::DistW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [crle_pkg::AddrW-1:0] raddr_i,
  output logic [crle_pkg::DistW-1:0] rdata_o
);
  import crle_pkg::*;

  localparam int unsigned Depth = MaxPoints * MaxPoints;

  logic [DistW-1:0] mem_q [Depth];
  logic [DistW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/crle_accum.sv =====
module crle_accum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  crle_pkg::accum_ctrl_t      ctrl_i,
  input  logic [crle_pkg::DistW-1:0] term_i,
  output logic [crle_pkg::LenW-1:0]  sum_o,
  output logic                       sat_o
);
  import crle_pkg::*;

  logic [LenW-1:0] sum_q, sum_d;
  logic            sat_q, sat_d;
  logic [LenW:0]   wide_sum;

  assign wide_sum = {1'b0, sum_q} + {{(LenW + 1 - DistW){1'b0}}, term_i};

  always_comb begin
    sum_d = sum_q;
    sat_d = sat_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
      sat_d = 1'b0;
    end else if (ctrl_i.add) begin
      // clamp at all ones on carry out
      if (wide_sum[LenW]) begin
        sum_d = '1;
        sat_d = 1'b1;
      end else begin
        sum_d = wide_sum[LenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      sat_q <= sat_d;
    end
  end

  assign sum_o = sum_q;
  assign sat_o = sat_q;

endmodule

// ===== rtl/closed_route_length_evaluator_unit.sv =====
// Write item: accepted while idle; the block is ready again the next cycle.
// Route item: one table read, then accumulate; a node marked last also takes a
// second read of the same port for the facility term, a second accumulate and
// the output handshake. No new item is taken until the block is back in idle.
// Reset clears route state, node count and the handshake; the distance table
// keeps whatever it held and must be written before it is read.
module closed_route_length_evaluator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  crle_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output crle_pkg::out_item_t         out_item_o,
  input  logic                        cfg_we_i,
  input  logic [crle_pkg::CountW-1:0] cfg_wdata_i
);
  import crle_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,   // wait for an item
    StAcc1 = 4'b0010,   // first term arrives from the table
    StAcc2 = 4'b0100,   // facility term of the last node arrives
    StOut  = 4'b1000    // hold the result until taken
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0] node_count_q;
  logic [IdxW-1:0]   prev_q, prev_d;
  logic [IdxW-1:0]   fac_q, fac_d;
  logic [IdxW-1:0]   node_q, node_d;
  logic              last_q, last_d;
  logic              zero_q, zero_d;   // masks a term whose row left the table
  logic              bad_q, bad_d;

  logic              accept;
  logic [RowW-1:0]   frow_in;
  logic [RowW-1:0]   frow_cur;
  logic              frow_in_bad;
  logic              frow_cur_bad;

  logic              tbl_we;
  logic              tbl_re;
  logic [AddrW-1:0]  tbl_raddr;
  logic [AddrW-1:0]  tbl_waddr;
  logic [DistW-1:0]  tbl_rdata;
  logic [DistW-1:0]  term;

  accum_ctrl_t       acc_ctrl;
  logic [LenW-1:0]   acc_sum;
  logic              acc_sat;

  assign accept     = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);

  // facility rows sit after the customer rows
  assign frow_in      = {{(RowW - IdxW){1'b0}}, in_item_i.facility_index}
                        + {{(RowW - CountW){1'b0}}, node_count_q};
  assign frow_cur     = {{(RowW - IdxW){1'b0}}, fac_q}
                        + {{(RowW - CountW){1'b0}}, node_count_q};
  assign frow_in_bad  = (frow_in >= RowW'(MaxPoints));
  assign frow_cur_bad = (frow_cur >= RowW'(MaxPoints));

  assign tbl_waddr = {in_item_i.row_index, in_item_i.col_index};
  assign term      = zero_q ? '0 : tbl_rdata;

  always_comb begin
    state_d   = state_q;
    prev_d    = prev_q;
    fac_d     = fac_q;
    node_d    = node_q;
    last_d    = last_q;
    zero_d    = zero_q;
    bad_d     = bad_q;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    tbl_raddr = {prev_q, node_q};
    acc_ctrl  = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_item_i.operation == OpWrite) begin
            tbl_we = 1'b1;
          end else begin
            node_d  = in_item_i.node_index;
            prev_d  = in_item_i.node_index;
            last_d  = in_item_i.last_of_route;
            tbl_re  = 1'b1;
            state_d = StAcc1;
            if (in_item_i.first_of_route) begin
              // start a new route: clear the sum, read facility to first node
              fac_d          = in_item_i.facility_index;
              bad_d          = frow_in_bad;
              zero_d         = frow_in_bad;
              acc_ctrl.clear = 1'b1;
              tbl_raddr      = {frow_in[IdxW-1:0], in_item_i.node_index};
            end else begin
              zero_d    = 1'b0;
              tbl_raddr = {prev_q, in_item_i.node_index};
            end
          end
        end
      end
      StAcc1: begin
        acc_ctrl.add = 1'b1;
        if (last_q) begin
          // close the route: fetch facility to last node
          tbl_re    = 1'b1;
          tbl_raddr = {frow_cur[IdxW-1:0], node_q};
          zero_d    = frow_cur_bad;
          bad_d     = bad_q || frow_cur_bad;
          state_d   = StAcc2;
        end else begin
          state_d = StIdle;
        end
      end
      StAcc2: begin
        acc_ctrl.add = 1'b1;
        state_d      = StOut;
      end
      StOut: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      node_count_q <= '0;
      prev_q       <= '0;
      fac_q        <= '0;
      node_q       <= '0;
      last_q       <= 1'b0;
      zero_q       <= 1'b0;
      bad_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
      fac_q   <= fac_d;
      node_q  <= node_d;
      last_q  <= last_d;
      zero_q  <= zero_d;
      bad_q   <= bad_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  crle_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (in_item_i.distance),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  crle_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (acc_ctrl),
    .term_i (term),
    .sum_o  (acc_sum),
    .sat_o  (acc_sat)
  );

  // result holds in the accumulator until the item is taken
  assign out_valid_o             = (state_q == StOut);
  assign out_item_o.route_length = acc_sum;
  assign out_item_o.saturated    = acc_sat;
  assign out_item_o.index_error  = bad_q;

endmodule

// ===== tb/sv/tb_closed_route_length_evaluator_unit.sv =====
`timescale 1ns / 1ps

module tb_closed_route_length_evaluator_unit;
  import crle_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 20;
  // lets a route item still inside the block get back to idle before a node count write
  localparam int SettleCycles = 8;
  localparam logic [DistW-1:0] DistMax = '1;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_item_t          in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_item_t         out_item_o;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;

  closed_route_length_evaluator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the block's state, advanced in item order as items go out.
  logic [DistW-1:0]  dist_copy [MaxPoints][MaxPoints];
  bit                entry_set [MaxPoints][MaxPoints];
  logic [LenW-1:0]   acc_len      = '0;
  logic [IdxW-1:0]   last_node    = '0;
  logic [IdxW-1:0]   fac_sel      = '0;
  bit                sat_flag     = 1'b0;
  bit                row_err_flag = 1'b0;
  logic [CountW-1:0] nodes_cfg    = '0;

  // Route lengths predicted but not yet seen at the output, oldest first.
  out_item_t pending_lengths[$];

  bit idle_on  = 1'b1;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  int cycle_count   = 0;
  int fail_count    = 0;
  int items_sent    = 0;
  int n_writes      = 0;
  int n_nodes       = 0;
  int n_routes      = 0;
  int n_saturated   = 0;
  int n_bad_row     = 0;
  int n_checked     = 0;
  int n_cfg_writes  = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [DistW-1:0] lookup_dist(input int row, input int col);
    // rows past the table contribute nothing
    if (row >= MaxPoints || col >= MaxPoints) return '0;
    return dist_copy[row][col];
  endfunction

  function automatic void add_term(input logic [DistW-1:0] term);
    logic [LenW:0] sum;
    sum = {1'b0, acc_len} + {{(LenW + 1 - DistW){1'b0}}, term};
    if (sum[LenW]) begin
      acc_len  = '1;
      sat_flag = 1'b1;
    end else begin
      acc_len = sum[LenW-1:0];
    end
  endfunction

  function automatic void predict_route_node(input in_item_t item);
    int frow;
    if (item.first_of_route) begin
      fac_sel      = item.facility_index;
      acc_len      = '0;
      sat_flag     = 1'b0;
      frow         = int'(fac_sel) + int'(nodes_cfg);
      row_err_flag = (frow >= MaxPoints);
      add_term(lookup_dist(frow, int'(item.node_index)));
    end else begin
      add_term(lookup_dist(int'(last_node), int'(item.node_index)));
    end
    last_node = item.node_index;
    if (item.last_of_route) begin
      // node count is read again here, so a change mid-route moves the row
      frow = int'(fac_sel) + int'(nodes_cfg);
      if (frow >= MaxPoints) row_err_flag = 1'b1;
      add_term(lookup_dist(frow, int'(item.node_index)));
      pending_lengths.push_back('{route_length: acc_len, saturated: sat_flag,
                                  index_error: row_err_flag});
      n_routes++;
      if (sat_flag) n_saturated++;
      if (row_err_flag) n_bad_row++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  function automatic in_item_t random_bits();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [DistW-1:0] pick_distance();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return DistMax;
    return DistW'($urandom_range(0, 32'hFF_FFFF));
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input in_item_t item);
    if (idle_on && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_write(input int row, input int col, input logic [DistW-1:0] value);
    in_item_t item;
    item           = random_bits();
    item.operation = OpWrite;
    item.row_index = IdxW'(row);
    item.col_index = IdxW'(col);
    item.distance  = value;
    dist_copy[row][col] = value;
    entry_set[row][col] = 1'b1;
    n_writes++;
    send_item(item);
  endtask

  // Load an entry before its first read; the table powers up undefined.
  task automatic fill_entry(input int row, input int col);
    if (!entry_set[row][col]) send_write(row, col, pick_distance());
  endtask

  task automatic send_node(input int fac, input int node, input bit first, input bit last);
    in_item_t item;
    int       frow;
    if (first) begin
      frow = fac + int'(nodes_cfg);
      if (frow < MaxPoints) fill_entry(frow, node);
    end else begin
      fill_entry(int'(last_node), node);
    end
    if (last) begin
      frow = (first ? fac : int'(fac_sel)) + int'(nodes_cfg);
      if (frow < MaxPoints) fill_entry(frow, node);
    end
    item                = random_bits();
    item.operation      = OpRoute;
    item.facility_index = IdxW'(fac);
    item.node_index     = IdxW'(node);
    item.first_of_route = first;
    item.last_of_route  = last;
    predict_route_node(item);
    n_nodes++;
    send_item(item);
  endtask

  // Write node_count only with the block drained and quiet.
  task automatic set_node_count(input logic [CountW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    nodes_cfg = value;
    n_cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall at random or for a requested stretch, check each result
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lengths.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] route length %h with no route pending", $realtime,
                   out_item_o.route_length);
      end else begin
        want = pending_lengths.pop_front();
        n_checked++;
        if (out_item_o.route_length !== want.route_length ||
            out_item_o.saturated    !== want.saturated    ||
            out_item_o.index_error  !== want.index_error) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] route %0d: expected len=%h sat=%b err=%b, got len=%h sat=%b err=%b",
                     $realtime, n_checked, want.route_length, want.saturated,
                     want.index_error, out_item_o.route_length, out_item_o.saturated,
                     out_item_o.index_error);
        end
      end
    end
    // a new hold request wins over random stalling
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 10);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d route lengths still pending",
               cycle_count, pending_lengths.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners of the table and of the distance range, node count at reset value.
  task automatic test_table_extremes();
    send_write(0, 0, '0);
    send_write(63, 63, DistMax);
    send_write(63, 0, 24'h00_0001);
    send_write(0, 63, 24'h80_0000);
    send_node(63, 63, 1'b1, 1'b0);
    send_node(0, 0, 1'b0, 1'b0);
    send_node(17, 63, 1'b0, 1'b1);
  endtask

  // First and last on one node: the facility term counts twice.
  task automatic test_single_node_route();
    send_write(5, 5, 24'h12_3456);
    send_node(5, 5, 1'b1, 1'b1);
  endtask

  // Nodes with no first mark keep adding onto what the last route left.
  task automatic test_unmarked_nodes();
    send_node(9, 7, 1'b0, 1'b0);
    send_node(9, 9, 1'b0, 1'b1);
  endtask

  // Facility row past the table: terms count zero, flag set.
  task automatic test_bad_facility_row();
    set_node_count(7'd64);
    send_node(0, 3, 1'b1, 1'b0);
    send_node(0, 4, 1'b0, 1'b1);
    send_node(63, 62, 1'b1, 1'b1);
  endtask

  // Node count changes between first and last node of one route.
  task automatic test_count_change_mid_route();
    set_node_count(7'd10);
    send_node(2, 1, 1'b1, 1'b0);
    set_node_count(7'd50);
    send_node(2, 2, 1'b0, 1'b1);
    // valid row at first node, row past the table at last node
    set_node_count(7'd40);
    send_node(20, 6, 1'b1, 1'b0);
    set_node_count(7'd60);
    send_node(20, 8, 1'b0, 1'b1);
  endtask

  // A table write in the middle of a route leaves the route alone
  // and the rewritten entry is read afterwards.
  task automatic test_write_mid_route();
    set_node_count(7'd0);
    send_node(4, 11, 1'b1, 1'b0);
    send_write(11, 12, 24'hAB_CDEF);
    send_write(4, 12, pick_distance());
    send_node(4, 12, 1'b0, 1'b1);
  endtask

  // Long heavy route pushes the sum to the top; the next route starts clean.
  task automatic test_saturation();
    send_write(0, 1, DistMax);
    send_write(1, 0, DistMax);
    send_write(2, 0, DistMax);
    send_node(2, 0, 1'b1, 1'b0);
    for (int k = 1; k < 300; k++) send_node(2, k % 2, 1'b0, k == 299);
    send_node(2, 0, 1'b1, 1'b1);
  endtask

  // Hold the output for a long stretch and keep offering routes so the
  // block fills up and stalls its input.
  task automatic test_backpressure();
    idle_on  <= 1'b0;
    hold_req <= hold_req + 1;
    for (int k = 0; k < 40; k++)
      send_node($urandom_range(0, 3), $urandom_range(0, 7), 1'b1, 1'b1);
    idle_on <= 1'b1;
  endtask

  task automatic random_route();
    int len;
    int fac;
    bit wide;
    wide = ($urandom_range(99) < 15);
    len  = ($urandom_range(99) < 10) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    fac  = wide ? $urandom_range(0, 63) : $urandom_range(0, 5);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < 5)
        send_write($urandom_range(0, 63), $urandom_range(0, 63), pick_distance());
      send_node(fac, wide ? $urandom_range(0, 63) : $urandom_range(0, 11), k == 0,
                k == len - 1);
    end
  endtask

  // Mostly well-formed routes; the rest is stray writes and routes with
  // missing or extra first and last marks.
  task automatic test_random_routes();
    logic [CountW-1:0] counts[6];
    int                target;
    int                roll;
    counts = '{7'd0, 7'd64, 7'd7, 7'd0, 7'd32, 7'd63};
    counts[3] = CountW'($urandom_range(1, 63));
    for (int p = 0; p < 6; p++) begin
      set_node_count(counts[p]);
      // one phase runs with no idling on either side
      idle_on <= (p != 2);
      target = items_sent + 165;
      while (items_sent < target) begin
        roll = $urandom_range(99);
        if (roll < 80) begin
          random_route();
        end else if (roll < 90) begin
          send_write($urandom_range(0, 63), $urandom_range(0, 63), pick_distance());
        end else begin
          send_node($urandom_range(0, 63), $urandom_range(0, 15),
                    $urandom_range(99) < 30, $urandom_range(99) < 30);
        end
      end
    end
    idle_on <= 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_extremes();
    test_single_node_route();
    test_unmarked_nodes();
    test_bad_facility_row();
    test_count_change_mid_route();
    test_write_mid_route();
    test_saturation();
    test_backpressure();
    test_random_routes();

    // drain, then give stray results time to show up
    in_valid_i <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d items: %0d table writes and %0d route nodes over %0d node count settings",
             items_sent, n_writes, n_nodes, n_cfg_writes);
    $display("Checked %0d route lengths, %0d saturated, %0d with a facility row off the table",
             n_checked, n_saturated, n_bad_row);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
